// File: hdl/mcat_pkg.sv
// shared types, constants and codes for the memory chunk address translator
package mcat_pkg;

  localparam int MAX_CHUNKS = 16;
  localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LIM_W      = $clog2(MAX_CHUNKS + 1);
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 5;
  localparam int SLOT_W     = 4;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_V2P   = 2'd1,
    OP_P2V   = 2'd2,
    OP_EOC   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_FIN,
    ST_DONE
  } state_t;

  // operands of the shared add/compare unit
  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] c;
    logic [ADDR_W-1:0] off;
  } alu_req_t;

  // results of the shared add/compare unit
  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] off_sum;
    logic              borrow;
    logic              lt;
  } alu_rsp_t;

  // chunk table write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } tbl_wr_t;

  // finished result from the sequencer
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic              hit;
  } res_t;

endpackage

// File: hdl/mcat_table.sv
// chunk base/size table, one write port and one registered read port
module mcat_table (
  input  logic                           clk,
  input  mcat_pkg::tbl_wr_t              wr,
  input  logic [mcat_pkg::IDX_W-1:0]     rd_addr,
  output logic [mcat_pkg::ADDR_W-1:0]    rd_base,
  output logic [mcat_pkg::ADDR_W-1:0]    rd_size
);

  logic [mcat_pkg::ADDR_W-1:0] base_mem [mcat_pkg::MAX_CHUNKS];
  logic [mcat_pkg::ADDR_W-1:0] size_mem [mcat_pkg::MAX_CHUNKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      base_mem[wr.addr] <= wr.base;
      size_mem[wr.addr] <= wr.size;
    end
    rd_base <= base_mem[rd_addr];
    rd_size <= size_mem[rd_addr];
  end

endmodule

// File: hdl/mcat_alu.sv
// shared add/subtract/compare unit used by every walk step
module mcat_alu (
  input  mcat_pkg::alu_req_t req,
  output mcat_pkg::alu_rsp_t rsp
);

  logic [mcat_pkg::ADDR_W-1:0] sum;

  assign sum         = req.a + req.b;
  assign rsp.sum     = sum;
  assign rsp.diff    = req.c - req.a;
  assign rsp.borrow  = (req.c < req.a);
  assign rsp.lt      = (req.c < sum);
  assign rsp.off_sum = req.off + req.b;

endmodule

// File: hdl/mcat_seq.sv
// sequencer: accepts one transaction, walks the chunk table, forms the result
module mcat_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           idle,
  input  logic [1:0]                     opcode,
  input  logic [mcat_pkg::ADDR_W-1:0]    address,
  input  logic [mcat_pkg::ADDR_W-1:0]    length,
  input  logic [mcat_pkg::SLOT_W-1:0]    entry_index,
  input  logic [mcat_pkg::ADDR_W-1:0]    entry_base,
  input  logic [mcat_pkg::ADDR_W-1:0]    entry_size,
  input  logic [mcat_pkg::CNT_W-1:0]     chunk_count,
  output mcat_pkg::tbl_wr_t              tbl_wr,
  output logic [mcat_pkg::IDX_W-1:0]     tbl_rd_addr,
  input  logic [mcat_pkg::ADDR_W-1:0]    tbl_base,
  input  logic [mcat_pkg::ADDR_W-1:0]    tbl_size,
  output mcat_pkg::alu_req_t             alu_req,
  input  mcat_pkg::alu_rsp_t             alu_rsp,
  input  logic                           out_free,
  output mcat_pkg::res_t                 res
);

  mcat_pkg::state_t state, state_next;
  mcat_pkg::op_t    op, op_next, op_in;
  logic [mcat_pkg::ADDR_W-1:0] addr_r, addr_r_next;
  logic [mcat_pkg::ADDR_W-1:0] len_r, len_r_next;   // holds address + length after load
  logic [mcat_pkg::ADDR_W-1:0] off, off_next;
  logic [mcat_pkg::ADDR_W-1:0] res_r, res_r_next;
  logic                        hit_r, hit_r_next;
  logic [mcat_pkg::IDX_W-1:0]  idx, idx_next;
  logic [mcat_pkg::LIM_W-1:0]  limit, limit_next;
  logic [mcat_pkg::LIM_W-1:0]  limit_in;
  logic                        slot_ok;
  logic                        match;

  assign op_in    = mcat_pkg::op_t'(opcode);
  assign slot_ok  = (32'(entry_index) < 32'(mcat_pkg::MAX_CHUNKS));
  assign limit_in = (32'(chunk_count) > 32'(mcat_pkg::MAX_CHUNKS)) ?
                    mcat_pkg::LIM_W'(mcat_pkg::MAX_CHUNKS) :
                    mcat_pkg::LIM_W'(chunk_count);

  assign idle = (state == mcat_pkg::ST_IDLE);

  // table writes go straight from the accepted transaction
  assign tbl_wr.en   = start && (op_in == mcat_pkg::OP_WRITE) && slot_ok;
  assign tbl_wr.addr = mcat_pkg::IDX_W'(entry_index);
  assign tbl_wr.base = entry_base;
  assign tbl_wr.size = entry_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    op     <= op_next;
    addr_r <= addr_r_next;
    len_r  <= len_r_next;
    off    <= off_next;
    res_r  <= res_r_next;
    hit_r  <= hit_r_next;
    idx    <= idx_next;
    limit  <= limit_next;
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    addr_r_next = addr_r;
    len_r_next  = len_r;
    off_next    = off;
    res_r_next  = res_r;
    hit_r_next  = hit_r;
    idx_next    = idx;
    limit_next  = limit;
    tbl_rd_addr = '0;
    alu_req     = '0;
    match       = 1'b0;
    res.valid   = 1'b0;
    res.address = res_r;
    res.hit     = hit_r;

    case (state)
      mcat_pkg::ST_IDLE: begin
        if (start) begin
          op_next     = op_in;
          addr_r_next = address;
          len_r_next  = length;
          off_next    = '0;
          idx_next    = '0;
          limit_next  = limit_in;
          hit_r_next  = 1'b0;
          if (op_in == mcat_pkg::OP_WRITE) begin
            res_r_next = '0;
            hit_r_next = slot_ok;
            state_next = mcat_pkg::ST_DONE;
          end else begin
            res_r_next = (op_in == mcat_pkg::OP_EOC) ? '0 : address;
            state_next = mcat_pkg::ST_LOAD;
          end
        end
      end

      mcat_pkg::ST_LOAD: begin
        // entry 0 is on the read port; form the end address for the test
        alu_req.a  = addr_r;
        alu_req.b  = len_r;
        len_r_next = alu_rsp.sum;
        if (limit == '0) begin
          state_next = mcat_pkg::ST_DONE;
        end else begin
          state_next = mcat_pkg::ST_WALK;
        end
      end

      mcat_pkg::ST_WALK: begin
        tbl_rd_addr = idx + 1'b1;
        alu_req.a   = (op == mcat_pkg::OP_V2P) ? off : tbl_base;
        alu_req.b   = tbl_size;
        alu_req.c   = addr_r;
        alu_req.off = off;
        case (op)
          mcat_pkg::OP_V2P: match = alu_rsp.lt;
          mcat_pkg::OP_P2V: match = !alu_rsp.borrow && alu_rsp.lt;
          mcat_pkg::OP_EOC: match = (alu_rsp.sum == len_r);
          default:          match = 1'b0;
        endcase
        off_next = alu_rsp.off_sum;
        if (match) begin
          hit_r_next = 1'b1;
          if (op == mcat_pkg::OP_EOC) begin
            state_next = mcat_pkg::ST_DONE;
          end else begin
            // partial result; the other term is added in the final step
            res_r_next = alu_rsp.diff;
            off_next   = (op == mcat_pkg::OP_V2P) ? tbl_base : off;
            state_next = mcat_pkg::ST_FIN;
          end
        end else if (mcat_pkg::LIM_W'(idx) + 1'b1 == limit) begin
          state_next = mcat_pkg::ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      mcat_pkg::ST_FIN: begin
        alu_req.a  = res_r;
        alu_req.b  = off;
        res_r_next = alu_rsp.sum;
        state_next = mcat_pkg::ST_DONE;
      end

      mcat_pkg::ST_DONE: begin
        if (out_free) begin
          res.valid  = 1'b1;
          state_next = mcat_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mcat_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/memory_chunk_address_translator.sv
// top level: config register, chunk table, shared unit, sequencer and output register
// steps: write: accept, result; end-of-chunk test: accept, load, walk, result; translations
//   also a final add on a hit; the walk covers up to limit = min(count, 16) entries
// throughput: one transaction at a time, set by the one-entry-per-cycle table walk
//   through the single read port and the shared add/compare unit, and by output backpressure
// reset: rst clears the sequencer, the output valid and chunk_count; the table is not cleared
module memory_chunk_address_translator (
  input  logic                           clk,
  input  logic                           rst,
  // configuration: chunk_count
  input  logic                           cfg_we,
  input  logic [mcat_pkg::CNT_W-1:0]     cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [mcat_pkg::ADDR_W-1:0]    address,
  input  logic [mcat_pkg::ADDR_W-1:0]    length,
  input  logic [mcat_pkg::SLOT_W-1:0]    entry_index,
  input  logic [mcat_pkg::ADDR_W-1:0]    entry_base,
  input  logic [mcat_pkg::ADDR_W-1:0]    entry_size,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mcat_pkg::ADDR_W-1:0]    result_address,
  output logic                           hit
);

  logic [mcat_pkg::CNT_W-1:0]  chunk_count;
  logic                        start;
  logic                        seq_idle;
  logic                        out_free;
  mcat_pkg::tbl_wr_t           tbl_wr;
  logic [mcat_pkg::IDX_W-1:0]  tbl_rd_addr;
  logic [mcat_pkg::ADDR_W-1:0] tbl_base;
  logic [mcat_pkg::ADDR_W-1:0] tbl_size;
  mcat_pkg::alu_req_t          alu_req;
  mcat_pkg::alu_rsp_t          alu_rsp;
  mcat_pkg::res_t              res;

  // new transaction taken whenever the sequencer is idle, even while
  // the previous result still waits in the output register
  assign in_ready = seq_idle;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // chunk count register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= '0;
    end else if (cfg_we) begin
      chunk_count <= cfg_wdata;
    end
  end

  // output register, loaded by the sequencer only when it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res.valid) begin
      result_address <= res.address;
      hit            <= res.hit;
    end
  end

  mcat_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (tbl_rd_addr),
    .rd_base (tbl_base),
    .rd_size (tbl_size)
  );

  mcat_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  mcat_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .idle        (seq_idle),
    .opcode      (opcode),
    .address     (address),
    .length      (length),
    .entry_index (entry_index),
    .entry_base  (entry_base),
    .entry_size  (entry_size),
    .chunk_count (chunk_count),
    .tbl_wr      (tbl_wr),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_base    (tbl_base),
    .tbl_size    (tbl_size),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp),
    .out_free    (out_free),
    .res         (res)
  );

endmodule
